### design/s7so_pkg.sv
// ----------------------------------------------------------------------------
// s7so_pkg
// shared types, widths and the segment table for the score display driver
// ----------------------------------------------------------------------------
package s7so_pkg;

    localparam int SCORE_W = 16;
    localparam int POS_W   = 5;
    localparam int SEG_W   = 8;
    localparam int BCD_W   = 4;
    localparam int CNT_W   = $clog2(SCORE_W + 1);

    typedef logic [BCD_W-1:0] t_digit;
    typedef logic [SEG_W-1:0] t_seg;

    // control shared by every digit cell
    typedef struct packed {
        logic clear;
        logic shift;
    } t_cell_ctl;

    // common-cathode pattern, bit 7 = segment a, bit 0 = decimal point
    function automatic t_seg seg_of(input t_digit d);
        t_seg s;
        case (d)
            4'd0:    s = 8'b1111_1100;
            4'd1:    s = 8'b0110_0000;
            4'd2:    s = 8'b1101_1010;
            4'd3:    s = 8'b1111_0010;
            4'd4:    s = 8'b0110_0110;
            4'd5:    s = 8'b1011_0110;
            4'd6:    s = 8'b1011_1110;
            4'd7:    s = 8'b1110_0000;
            4'd8:    s = 8'b1111_1110;
            4'd9:    s = 8'b1111_0110;
            default: s = 8'b0000_0000;
        endcase
        return s;
    endfunction

endpackage

### design/s7so_bcd_cell.sv
// ----------------------------------------------------------------------------
// s7so_bcd_cell
// one decimal digit of the shift-and-add-three chain, with blanking
// ----------------------------------------------------------------------------
module s7so_bcd_cell (
    input  logic                 i_clk,
    input  s7so_pkg::t_cell_ctl  i_ctl,
    input  logic                 i_shift_in,
    input  logic                 i_blank_in,
    input  logic                 i_force_show,
    output logic                 o_carry,
    output logic                 o_blank_out,
    output s7so_pkg::t_seg       o_segments
);
    import s7so_pkg::*;

    t_digit r_digit;
    t_digit n_digit;
    t_digit w_adj;

    // add three before the shift when the digit would overflow past nine
    assign w_adj   = (r_digit >= t_digit'(5)) ? t_digit'(r_digit + t_digit'(3)) : r_digit;
    assign o_carry = w_adj[BCD_W-1];

    always_comb begin
        n_digit = r_digit;
        if (i_ctl.clear) begin
            n_digit = '0;
        end else if (i_ctl.shift) begin
            n_digit = {w_adj[BCD_W-2:0], i_shift_in};
        end
    end

    always_ff @(posedge i_clk) begin
        r_digit <= n_digit;
    end

    // blank while this digit and every digit above it are zero
    assign o_blank_out = i_blank_in && (r_digit == '0);
    assign o_segments  = (o_blank_out && !i_force_show) ? '0 : seg_of(r_digit);

endmodule

### design/s7so_serialiser.sv
// ----------------------------------------------------------------------------
// s7so_serialiser
// shifts the segment bytes out one bit per item, latch on the final bit
// ----------------------------------------------------------------------------
module s7so_serialiser #(
    parameter int NUM_DIGITS = 4
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_load,
    input  logic [NUM_DIGITS*8-1:0]     i_data,
    input  logic                        i_stall,
    output logic                        o_free,
    output logic                        o_valid,
    output logic                        o_serial_bit,
    output logic [s7so_pkg::POS_W-1:0]  o_bit_position,
    output logic                        o_latch
);
    import s7so_pkg::*;

    localparam int RUN_LEN = NUM_DIGITS * SEG_W;
    localparam int RUN_W   = $clog2(RUN_LEN);
    localparam int EXT_W   = (RUN_W > POS_W) ? RUN_W : POS_W;

    logic [RUN_LEN-1:0] r_shift;
    logic [RUN_LEN-1:0] n_shift;
    logic [RUN_W-1:0]   r_cnt;
    logic [RUN_W-1:0]   n_cnt;
    logic               r_valid;
    logic               n_valid;
    logic               w_accept;
    logic               w_last;
    logic [EXT_W-1:0]   w_pos_ext;

    assign w_accept = r_valid && !i_stall;
    assign w_last   = (r_cnt == RUN_W'(RUN_LEN - 1));
    assign o_free   = !r_valid || (w_accept && w_last);

    always_comb begin
        n_shift = r_shift;
        n_cnt   = r_cnt;
        n_valid = r_valid;
        if (i_load) begin
            n_shift = i_data;
            n_cnt   = '0;
            n_valid = 1'b1;
        end else if (w_accept) begin
            if (w_last) begin
                n_valid = 1'b0;
            end else begin
                n_shift = {1'b0, r_shift[RUN_LEN-1:1]};
                n_cnt   = RUN_W'(r_cnt + 1'b1);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
            r_cnt   <= '0;
        end else begin
            r_valid <= n_valid;
            r_cnt   <= n_cnt;
        end
        r_shift <= n_shift;
    end

    // position wraps within its five bits on longer runs
    assign w_pos_ext      = EXT_W'(r_cnt);
    assign o_valid        = r_valid;
    assign o_serial_bit   = r_shift[0];
    assign o_bit_position = w_pos_ext[POS_W-1:0];
    assign o_latch        = w_last;

endmodule

### design/score_to_seven_segment_shift_out_core.sv
// ----------------------------------------------------------------------------
// score_to_seven_segment_shift_out_core
// score to seven-segment bytes, shifted out for a chain of shift registers
// ----------------------------------------------------------------------------
// usage
//   input channel: one item is a 16-bit score on i_score, taken when i_valid
//   is high and o_stall is low. output channel: one item is one shift clock,
//   o_serial_bit with o_bit_position, taken when o_valid is high and i_stall
//   low. o_latch marks the last bit of a run, the register clock follows it.
//   each score gives NUM_DIGITS*8 output items, units byte first, lsb first.
//   conversion: the digit cell chain takes one score bit per cycle, then
//   the bytes are handed to the serialiser and its first bit shows.
//   throughput: set by the serial port (one bit a cycle while the
//   receiver does not stall) or by the digit cell chain, whichever is
//   slower. a new score converts while the previous run is still
//   shifting out.
//   reset: synchronous, active low; both channels go idle and no stale run
//   is shown. a stalling receiver holds the current bit; the converted
//   digits then wait and o_stall stays high until the run has moved on.
// ----------------------------------------------------------------------------
module score_to_seven_segment_shift_out_core #(
    parameter int NUM_DIGITS = 4
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_valid,
    output logic                          o_stall,
    input  logic [s7so_pkg::SCORE_W-1:0]  i_score,
    output logic                          o_valid,
    input  logic                          i_stall,
    output logic                          o_serial_bit,
    output logic [s7so_pkg::POS_W-1:0]    o_bit_position,
    output logic                          o_latch
);
    import s7so_pkg::*;

    // converter states
    localparam logic [1:0] ST_IDLE = 2'd0;
    localparam logic [1:0] ST_BUSY = 2'd1;
    localparam logic [1:0] ST_DONE = 2'd2;

    logic [1:0]               r_state;
    logic [1:0]               n_state;
    logic [SCORE_W-1:0]       r_bin;
    logic [SCORE_W-1:0]       n_bin;
    logic [CNT_W-1:0]         r_left;
    logic [CNT_W-1:0]         n_left;

    logic                     w_take;
    logic                     w_load;
    logic                     w_free;
    t_cell_ctl                w_ctl;
    logic [NUM_DIGITS:0]      w_carry;
    logic [NUM_DIGITS:0]      w_blank;
    logic [NUM_DIGITS*8-1:0]  w_bytes;

    assign o_stall = (r_state != ST_IDLE);
    assign w_take  = i_valid && !o_stall;
    // hand the bytes over as soon as the serialiser can start a new run
    assign w_load  = (r_state == ST_DONE) && w_free;

    always_comb begin
        n_state = r_state;
        n_bin   = r_bin;
        n_left  = r_left;
        case (r_state)
            ST_IDLE: begin
                if (w_take) begin
                    n_state = ST_BUSY;
                    n_bin   = i_score;
                    n_left  = CNT_W'(SCORE_W);
                end
            end
            ST_BUSY: begin
                n_bin  = {r_bin[SCORE_W-2:0], 1'b0};
                n_left = CNT_W'(r_left - 1'b1);
                if (r_left == CNT_W'(1)) begin
                    n_state = ST_DONE;
                end
            end
            ST_DONE: begin
                if (w_load) begin
                    n_state = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
            r_left  <= '0;
        end else begin
            r_state <= n_state;
            r_left  <= n_left;
        end
        r_bin <= n_bin;
    end

    // digits clear on the take, then shift once per score bit
    assign w_ctl.clear = w_take;
    assign w_ctl.shift = (r_state == ST_BUSY);

    // score enters the units cell msb first; carries ripple upward and the
    // top cell's carry falls off, which is the wrap modulo 10^NUM_DIGITS
    assign w_carry[0]          = r_bin[SCORE_W-1];
    // nothing above the top digit, so blanking starts there
    assign w_blank[NUM_DIGITS] = 1'b1;

    for (genvar k = 0; k < NUM_DIGITS; k++) begin : g_cell
        logic w_blank_out;
        s7so_bcd_cell u_cell (
            .i_clk        (i_clk),
            .i_ctl        (w_ctl),
            .i_shift_in   (w_carry[k]),
            .i_blank_in   (w_blank[k+1]),
            .i_force_show (k == 0),
            .o_carry      (w_carry[k+1]),
            .o_blank_out  (w_blank_out),
            .o_segments   (w_bytes[k*SEG_W +: SEG_W])
        );
        assign w_blank[k] = w_blank_out;
    end

    // units byte sits at the low end so it leaves first
    s7so_serialiser #(
        .NUM_DIGITS (NUM_DIGITS)
    ) u_ser (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_load         (w_load),
        .i_data         (w_bytes),
        .i_stall        (i_stall),
        .o_free         (w_free),
        .o_valid        (o_valid),
        .o_serial_bit   (o_serial_bit),
        .o_bit_position (o_bit_position),
        .o_latch        (o_latch)
    );

endmodule

### design/s7so_checker.sv
// ----------------------------------------------------------------------------
// s7so_checker
// port-level checks on the score display driver, bound to the top level
// ----------------------------------------------------------------------------
module s7so_checker #(
    parameter int NUM_DIGITS = 4
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_valid,
    input  logic                          o_stall,
    input  logic                          o_valid,
    input  logic                          i_stall,
    input  logic                          o_serial_bit,
    input  logic [s7so_pkg::POS_W-1:0]    o_bit_position,
    input  logic                          o_latch
);
    import s7so_pkg::*;

    // stalled bit holds still
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && i_stall |=> o_valid && $stable(o_serial_bit)
            && $stable(o_bit_position) && $stable(o_latch))
        else $error("stalled output item changed");

    // a run never breaks off before its latch bit
    a_run: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && !i_stall && !o_latch |=> o_valid
            && o_bit_position == POS_W'($past(o_bit_position) + 1'b1))
        else $error("run broke off or skipped a position");

    // latch only on the final bit of a run
    a_latch: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_latch |-> o_bit_position == POS_W'(NUM_DIGITS * SEG_W - 1))
        else $error("latch away from the end of the run");

    // a taken score keeps the converter busy
    a_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_valid && !o_stall |=> o_stall)
        else $error("score taken while converter free next cycle");

endmodule

bind score_to_seven_segment_shift_out_core s7so_checker #(
    .NUM_DIGITS (NUM_DIGITS)
) u_s7so_checker (.*);

### tb/tb_score_to_seven_segment_shift_out_core.sv
// ----------------------------------------------------------------------------
// tb_score_to_seven_segment_shift_out_core
// self-checking bench for the score to seven-segment shift-out driver
// ----------------------------------------------------------------------------
// scores go in one item at a time; every accepted score is turned into the
// run of shift clocks it should produce (units byte first, lsb first, latch
// on the last bit) and each bit the block hands out is checked against the
// oldest bit still owed. a short table of hand-picked scores comes first,
// then random scores under four patterns of sender gaps and receiver stalls.
// ----------------------------------------------------------------------------
module tb_score_to_seven_segment_shift_out_core;

    timeunit 1ns;
    timeprecision 1ps;

    import s7so_pkg::*;

    localparam int NUM_DIGITS     = 4;
    localparam int RUN_W          = NUM_DIGITS * SEG_W;
    localparam int CLK_HALF       = 4;
    localparam int RESET_CYCLES   = 7;
    // cycles after the last owed bit, well past the conversion latency
    localparam int TAIL_CYCLES    = 40;
    // cycles with no item moving on either side before we give up
    localparam int WATCHDOG_LIMIT = 4000;
    localparam int MAX_REPORTS    = 40;
    localparam int RANDOM_PER_PHASE = 34;
    localparam int N_PHASES       = 4;

    // segment bytes per decimal digit, bit 7 = a ... bit 1 = g, dp off
    localparam t_seg DIGIT_SEGS [10] = '{
        8'hFC, 8'h60, 8'hDA, 8'hF2, 8'h66,
        8'hB6, 8'hBE, 8'hE0, 8'hFE, 8'hF6
    };

    // one shift clock as the block should present it
    typedef struct {
        logic             serial_bit;
        logic [POS_W-1:0] bit_position;
        logic             latch;
    } t_shift_bit;

    // directed row: the run word holds bit n of the shift run at bit n,
    // so the units byte sits in bits 7:0; typed = 0 means use the predictor
    typedef struct packed {
        logic [SCORE_W-1:0] score;
        logic               typed;
        logic [RUN_W-1:0]   run;
    } t_score_row;

    localparam int N_DIRECTED = 24;
    localparam t_score_row DIRECTED [N_DIRECTED] = '{
        '{16'd0,     1'b1, 32'h0000_00FC},   // all zero: lone units "0"
        '{16'd1,     1'b1, 32'h0000_0060},
        '{16'd9,     1'b1, 32'h0000_00F6},
        '{16'd10,    1'b0, 32'h0},
        '{16'd99,    1'b0, 32'h0},
        '{16'd100,   1'b0, 32'h0},
        '{16'd1000,  1'b1, 32'h60FC_FCFC},   // inner zeros shown
        '{16'd1010,  1'b0, 32'h0},
        '{16'd1001,  1'b0, 32'h0},
        '{16'd9000,  1'b0, 32'h0},
        '{16'd9999,  1'b1, 32'hF6F6_F6F6},
        '{16'd10000, 1'b1, 32'h0000_00FC},   // wraps to zero
        '{16'd12345, 1'b1, 32'hDAF2_66B6},   // wraps to 2345
        '{16'd20000, 1'b1, 32'h0000_00FC},
        '{16'd65535, 1'b1, 32'hB6B6_F2B6},   // top of range, shows 5535
        '{16'd32768, 1'b0, 32'h0},
        '{16'd8888,  1'b1, 32'hFEFE_FEFE},
        '{16'd1234,  1'b1, 32'h60DA_F266},
        '{16'd5678,  1'b0, 32'h0},
        '{16'd7,     1'b0, 32'h0},
        '{16'd4070,  1'b0, 32'h0},
        '{16'd30005, 1'b0, 32'h0},
        '{16'd50505, 1'b0, 32'h0},           // leading zero after wrap
        '{16'd43690, 1'b0, 32'h0}
    };

    // sender gap and receiver stall odds, percent, per phase
    localparam int PHASE_GAP   [N_PHASES] = '{0, 75,  0, 24};
    localparam int PHASE_STALL [N_PHASES] = '{0,  0, 75, 24};

    logic               i_clk   = 1'b0;
    logic               i_rst_n = 1'b0;
    logic               i_valid = 1'b0;
    logic               o_stall;
    logic [SCORE_W-1:0] i_score = '0;
    logic               o_valid;
    logic               i_stall = 1'b0;
    logic               o_serial_bit;
    logic [POS_W-1:0]   o_bit_position;
    logic               o_latch;

    t_shift_bit owed_bits [$];
    int         mismatches   = 0;
    int         gap_pct      = 0;
    int         stall_pct    = 0;
    int         quiet_cycles = 0;

    score_to_seven_segment_shift_out_core #(
        .NUM_DIGITS(NUM_DIGITS)
    ) dut (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_valid        (i_valid),
        .o_stall        (o_stall),
        .i_score        (i_score),
        .o_valid        (o_valid),
        .i_stall        (i_stall),
        .o_serial_bit   (o_serial_bit),
        .o_bit_position (o_bit_position),
        .o_latch        (o_latch)
    );

    always #(CLK_HALF) i_clk = ~i_clk;

    // the whole shift run for one score, bit n of the result = nth bit out
    function automatic logic [RUN_W-1:0] segment_run(input logic [SCORE_W-1:0] score);
        int unsigned      modulus;
        int unsigned      place;
        int unsigned      rest;
        int unsigned      digit;
        bit               blanking;
        logic [RUN_W-1:0] run;
        modulus  = 1;
        for (int k = 0; k < NUM_DIGITS; k++) modulus *= 10;
        rest     = score % modulus;
        place    = modulus / 10;
        blanking = 1'b1;
        run      = '0;
        // most significant digit first so leading zeros can be blanked
        for (int i = 0; i < NUM_DIGITS; i++) begin
            digit = (rest / place) % 10;
            if (digit != 0 || i == NUM_DIGITS - 1) blanking = 1'b0;
            run[(NUM_DIGITS - 1 - i) * SEG_W +: SEG_W] = blanking ? '0 : DIGIT_SEGS[digit];
            place = place / 10;
        end
        return run;
    endfunction

    // queue up every shift clock that one accepted score owes
    task automatic owe_run(input logic [RUN_W-1:0] run);
        t_shift_bit b;
        for (int n = 0; n < RUN_W; n++) begin
            b.serial_bit   = run[n];
            b.bit_position = POS_W'(n);
            b.latch        = (n == RUN_W - 1);
            owed_bits.push_back(b);
        end
    endtask

    // offer one score, with random gaps ahead of it, and wait for the take
    task automatic offer_score(input logic [SCORE_W-1:0] score);
        while ($urandom_range(0, 99) < gap_pct) begin
            i_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_valid <= 1'b1;
        i_score <= score;
        @(posedge i_clk);
        while (o_stall) @(posedge i_clk);
    endtask

    task automatic report_bad(input string what, input int want, input int got);
        mismatches++;
        if (mismatches <= MAX_REPORTS)
            $display("%0t: %s expected %0d got %0d", $realtime, what, want, got);
    endtask

    // random score, skewed towards short numbers and inner zeros
    function automatic logic [SCORE_W-1:0] pick_score();
        int unsigned v;
        case ($urandom_range(0, 4))
            0: v = $urandom_range(0, 65535);
            1: v = $urandom_range(0, 9999);
            2: v = $urandom_range(0, 999);
            3: v = $urandom_range(0, 99);
            default: begin
                // four digits, each zero half the time
                v = 0;
                for (int k = 0; k < 4; k++)
                    v = v * 10 + (($urandom_range(0, 1) == 0) ? 0 : $urandom_range(1, 9));
            end
        endcase
        return SCORE_W'(v);
    endfunction

    // receiver side: stall at random with the current phase's odds
    always @(posedge i_clk) begin
        i_stall <= ($urandom_range(0, 99) < stall_pct);
    end

    // every bit taken must match the oldest bit still owed
    always @(posedge i_clk) begin : take_bit
        t_shift_bit want;
        if (i_rst_n && o_valid && !i_stall) begin
            if (owed_bits.size() == 0) begin
                report_bad("unexpected bit at position", -1, o_bit_position);
            end else begin
                want = owed_bits.pop_front();
                if (o_serial_bit !== want.serial_bit)
                    report_bad("serial_bit", want.serial_bit, o_serial_bit);
                if (o_bit_position !== want.bit_position)
                    report_bad("bit_position", want.bit_position, o_bit_position);
                if (o_latch !== want.latch)
                    report_bad("latch", want.latch, o_latch);
            end
        end
    end

    // watchdog: nothing moving on either side for too long means a hang
    always @(posedge i_clk) begin
        if (!i_rst_n || (i_valid && !o_stall) || (o_valid && !i_stall))
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= WATCHDOG_LIMIT) begin
            $display("%0t: no item moved for %0d cycles", $realtime, WATCHDOG_LIMIT);
            $display("score_to_seven_segment_shift_out_core: mismatch");
            $finish;
        end
    end

    initial begin
        t_score_row         row;
        logic [SCORE_W-1:0] score;
        repeat (RESET_CYCLES) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // hand-picked scores, back to back with no gaps or stalls
        for (int r = 0; r < N_DIRECTED; r++) begin
            row = DIRECTED[r];
            offer_score(row.score);
            owe_run(row.typed ? row.run : segment_run(row.score));
        end

        // random scores under each pattern of gaps and stalls in turn
        for (int p = 0; p < N_PHASES; p++) begin
            gap_pct   = PHASE_GAP[p];
            stall_pct = PHASE_STALL[p];
            for (int k = 0; k < RANDOM_PER_PHASE; k++) begin
                score = pick_score();
                offer_score(score);
                owe_run(segment_run(score));
            end
        end
        i_valid <= 1'b0;

        // drain, then give the block a little longer to show any stray bits
        while (owed_bits.size() != 0) @(posedge i_clk);
        repeat (TAIL_CYCLES) @(posedge i_clk);
        if (owed_bits.size() != 0) report_bad("bits left owed", 0, owed_bits.size());

        if (mismatches == 0)
            $display("score_to_seven_segment_shift_out_core: match");
        else
            $display("score_to_seven_segment_shift_out_core: mismatch");
        $finish;
    end

endmodule

### filelist.f
design/s7so_pkg.sv
design/s7so_bcd_cell.sv
design/s7so_serialiser.sv
design/score_to_seven_segment_shift_out_core.sv
design/s7so_checker.sv
tb/tb_score_to_seven_segment_shift_out_core.sv
